### rtl/mlf_pkg.sv
// Shared types, codes and helpers for the memory LCD frame line formatter.
package mlf_pkg;

    localparam int DEF_PANEL_COLUMNS = 128;
    localparam int DEF_PANEL_ROWS    = 128;

    // Coordinate widths cover the largest panel the block supports.
    localparam int COORD_COL_W = 10;
    localparam int COORD_ROW_W = 8;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int OUT_FIFO_DEPTH = 2;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_RECT    = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    localparam logic [1:0] OP_FILL    = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [7:0] LINE_CMD_BYTE  = 8'h01;
    localparam logic [7:0] CLEAR_CMD_BYTE = 8'h04;
    localparam logic [7:0] TRAILER_BYTE   = 8'h00;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] x;
        logic [6:0] y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic       color;
        logic [6:0] refresh_row;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_rsp;

    // Classified command: a pixel is a one by one fill, column and row ends exclusive.
    typedef struct packed {
        logic [1:0]             op;
        logic [COORD_COL_W-1:0] col_lo;
        logic [COORD_COL_W-1:0] col_hi;
        logic [COORD_ROW_W-1:0] row_lo;
        logic [COORD_ROW_W-1:0] row_hi;
        logic                   color;
    } t_cmd;

    function automatic logic [7:0] bit_reverse(input logic [7:0] v);
        logic [7:0] b;
        b = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((b & 8'hCC) >> 2) | ((b & 8'h33) << 2);
        b = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
        return b;
    endfunction

endpackage

### rtl/mlf_fifo.sv
// Small synchronous queue used between the front and back and on the result side.
module mlf_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T                 r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/mlf_front.sv
// Front end: decodes a request, clips it to the panel and drops requests that do nothing.
module mlf_front #(
    parameter int EFF_COLS = mlf_pkg::DEF_PANEL_COLUMNS,
    parameter int ROWS     = mlf_pkg::DEF_PANEL_ROWS
) (
    input  mlf_pkg::t_req i_req,
    output logic          o_keep,
    output mlf_pkg::t_cmd o_cmd
);
    import mlf_pkg::*;

    logic [8:0] col_sum;
    logic [8:0] row_sum;

    always_comb begin
        o_cmd        = '0;
        o_keep       = 1'b0;
        o_cmd.color  = i_req.color;
        o_cmd.col_lo = COORD_COL_W'(i_req.x);
        o_cmd.row_lo = COORD_ROW_W'(i_req.y);
        col_sum      = 9'({2'b00, i_req.x}) + 9'd1;
        row_sum      = 9'({2'b00, i_req.y}) + 9'd1;
        if (i_req.req_type == REQ_RECT) begin
            col_sum = 9'({2'b00, i_req.x}) + 9'({1'b0, i_req.rect_width});
            row_sum = 9'({2'b00, i_req.y}) + 9'({1'b0, i_req.rect_height});
        end
        o_cmd.col_hi = (COORD_COL_W'(col_sum) > COORD_COL_W'(EFF_COLS)) ?
                       COORD_COL_W'(EFF_COLS) : COORD_COL_W'(col_sum);
        o_cmd.row_hi = (row_sum > 9'(ROWS)) ? COORD_ROW_W'(ROWS) : COORD_ROW_W'(row_sum);
        unique case (i_req.req_type)
            REQ_PIXEL, REQ_RECT: begin
                o_cmd.op = OP_FILL;
                o_keep   = (o_cmd.col_hi > o_cmd.col_lo) && (o_cmd.row_hi > o_cmd.row_lo);
            end
            REQ_REFRESH: begin
                o_cmd.op     = OP_REFRESH;
                o_cmd.row_lo = COORD_ROW_W'(i_req.refresh_row);
                o_keep       = (COORD_ROW_W'(i_req.refresh_row) < COORD_ROW_W'(ROWS));
            end
            default: begin
                o_cmd.op = OP_CLEAR;
                o_keep   = 1'b1;
            end
        endcase
    end

endmodule

### rtl/mlf_back.sv
// Back end: owns the frame store, runs fills and clear sweep, and formats output words.
module mlf_back #(
    parameter int PANEL_COLUMNS = mlf_pkg::DEF_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = mlf_pkg::DEF_PANEL_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mlf_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output logic          o_out_push,
    output mlf_pkg::t_rsp o_out,
    input  logic          i_out_full,
    output logic          o_clearing
);
    import mlf_pkg::*;

    localparam int LINE_BYTES  = PANEL_COLUMNS / 8;
    localparam int STORE_BYTES = PANEL_ROWS * LINE_BYTES;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BYTE_W      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CNT_W       = $clog2(LINE_BYTES + 4);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_REF   = 3'd2;
    localparam logic [2:0] ST_CMD   = 3'd3;
    localparam logic [2:0] ST_FRD   = 3'd4;
    localparam logic [2:0] ST_FWR   = 3'd5;

    localparam logic [ADDR_W-1:0] LB_A      = ADDR_W'(LINE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    logic [7:0]             r_mem [STORE_BYTES];
    logic [7:0]             r_q;

    logic [2:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [7:0]             r_line, n_line;
    logic [COORD_COL_W-1:0] r_col_lo, n_col_lo;
    logic [COORD_COL_W-1:0] r_col_hi, n_col_hi;
    logic [COORD_ROW_W-1:0] r_row, n_row;
    logic [COORD_ROW_W-1:0] r_row_hi, n_row_hi;
    logic [ADDR_W-1:0]      r_rowbase, n_rowbase;
    logic [BYTE_W-1:0]      r_xbyte, n_xbyte;
    logic [BYTE_W-1:0]      r_xfirst, n_xfirst;
    logic [BYTE_W-1:0]      r_xlast, n_xlast;
    logic                   r_color, n_color;

    // One pending output word; it comes either from the store read or from a byte register.
    logic                   r_pv, n_pv;
    logic                   r_pmem, n_pmem;
    logic [7:0]             r_pbyte, n_pbyte;
    logic                   r_plast, n_plast;

    logic                   push_out;
    logic                   emit_ok;
    logic [ADDR_W-1:0]      row_base;
    logic [ADDR_W-1:0]      fill_addr;
    logic [COORD_COL_W-1:0] col_hi_m1;
    logic [COORD_COL_W-1:0] col_i;
    logic [7:0]             mask;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [7:0]             mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    assign push_out     = r_pv && !i_out_full;
    assign emit_ok      = !r_pv || !i_out_full;
    assign o_out_push   = push_out;
    assign o_out.out_byte = r_pmem ? bit_reverse(r_q) : r_pbyte;
    assign o_out.last   = r_plast;
    assign o_clearing   = (r_state == ST_CLEAR);

    assign row_base  = ADDR_W'(i_cmd.row_lo) * LB_A;
    assign fill_addr = r_rowbase + ADDR_W'(r_xbyte);
    assign col_hi_m1 = i_cmd.col_hi - 1'b1;

    always_comb begin
        mask  = '0;
        col_i = '0;
        for (int i = 0; i < 8; i++) begin
            col_i        = COORD_COL_W'({r_xbyte, 3'(i)});
            mask[7 - i]  = (col_i >= r_col_lo) && (col_i < r_col_hi);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_addr    = r_addr;
        n_line    = r_line;
        n_col_lo  = r_col_lo;
        n_col_hi  = r_col_hi;
        n_row     = r_row;
        n_row_hi  = r_row_hi;
        n_rowbase = r_rowbase;
        n_xbyte   = r_xbyte;
        n_xfirst  = r_xfirst;
        n_xlast   = r_xlast;
        n_color   = r_color;
        n_pv      = r_pv && !push_out;
        n_pmem    = r_pmem;
        n_pbyte   = r_pbyte;
        n_plast   = r_plast;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = fill_addr;
        mem_wdata = r_color ? (r_q | mask) : (r_q & ~mask);
        mem_re    = 1'b0;
        mem_raddr = fill_addr;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '0;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        OP_REFRESH: begin
                            o_cmd_pop = 1'b1;
                            n_addr    = row_base;
                            n_line    = 8'(i_cmd.row_lo) + 8'd1;
                            n_cnt     = '0;
                            n_state   = ST_REF;
                        end
                        OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_cnt     = '0;
                            n_state   = ST_CMD;
                        end
                        default: begin
                            // The fill reuses the read register, so a pending output word
                            // has to leave first.
                            if (!r_pv) begin
                                o_cmd_pop = 1'b1;
                                n_col_lo  = i_cmd.col_lo;
                                n_col_hi  = i_cmd.col_hi;
                                n_row     = i_cmd.row_lo;
                                n_row_hi  = i_cmd.row_hi;
                                n_rowbase = row_base;
                                n_xfirst  = i_cmd.col_lo[3 +: BYTE_W];
                                n_xbyte   = i_cmd.col_lo[3 +: BYTE_W];
                                n_xlast   = col_hi_m1[3 +: BYTE_W];
                                n_color   = i_cmd.color;
                                n_state   = ST_FRD;
                            end
                        end
                    endcase
                end
            end
            ST_REF: begin
                if (emit_ok) begin
                    n_pv    = 1'b1;
                    n_pmem  = 1'b0;
                    n_plast = 1'b0;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == '0) begin
                        n_pbyte = LINE_CMD_BYTE | {6'b0, r_line[1], 1'b0};
                    end else if (r_cnt == CNT_W'(1)) begin
                        n_pbyte = r_line;
                    end else if (r_cnt < CNT_W'(LINE_BYTES + 2)) begin
                        n_pmem    = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = r_addr;
                        n_addr    = r_addr + 1'b1;
                    end else if (r_cnt == CNT_W'(LINE_BYTES + 2)) begin
                        n_pbyte = TRAILER_BYTE;
                    end else begin
                        n_pbyte = TRAILER_BYTE;
                        n_plast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CMD: begin
                if (emit_ok) begin
                    n_pv   = 1'b1;
                    n_pmem = 1'b0;
                    n_cnt  = r_cnt + 1'b1;
                    if (r_cnt == '0) begin
                        n_pbyte = CLEAR_CMD_BYTE;
                        n_plast = 1'b0;
                    end else begin
                        n_pbyte = TRAILER_BYTE;
                        n_plast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FRD: begin
                mem_re  = 1'b1;
                n_state = ST_FWR;
            end
            ST_FWR: begin
                mem_we  = 1'b1;
                n_state = ST_FRD;
                if (r_xbyte == r_xlast) begin
                    n_xbyte   = r_xfirst;
                    n_row     = r_row + 1'b1;
                    n_rowbase = r_rowbase + LB_A;
                    if (n_row == r_row_hi) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_xbyte = r_xbyte + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_line    <= n_line;
        r_col_lo  <= n_col_lo;
        r_col_hi  <= n_col_hi;
        r_row     <= n_row;
        r_row_hi  <= n_row_hi;
        r_rowbase <= n_rowbase;
        r_xbyte   <= n_xbyte;
        r_xfirst  <= n_xfirst;
        r_xlast   <= n_xlast;
        r_color   <= n_color;
        r_pmem    <= n_pmem;
        r_pbyte   <= n_pbyte;
        r_plast   <= n_plast;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_raddr];
        end
    end

endmodule

### rtl/memory_lcd_frame_line_formatter_unit.sv
// Top level of the memory LCD frame store and serial line formatter.
//
//   channel  | handshake          | word
//   ---------+--------------------+---------------------------------------------
//   request  | push / full        | t_req: pixel, rectangle, refresh, clear
//   result   | pop / empty        | t_rsp: one serial byte and its last flag
//
// A refresh sends its 2 + PANEL_COLUMNS/8 + 2 bytes at one byte per cycle while the
// result queue has room; a clear command sends the clear byte and a trailer byte.
// A fill does a read-modify-write of the single-port frame store, a read step and then a
// write step for every byte it touches in every row; a pixel is a fill of one byte.
// After reset the store is swept to zero at one byte a cycle, covering all of its
// PANEL_ROWS * PANEL_COLUMNS/8 bytes (2048 by default); full stays high until it ends.
// A full result queue stalls only the back end; requests keep queueing until full.
module memory_lcd_frame_line_formatter_unit #(
    parameter int PANEL_COLUMNS = mlf_pkg::DEF_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = mlf_pkg::DEF_PANEL_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  mlf_pkg::t_req i_req,
    output logic          full,
    input  logic          pop,
    output mlf_pkg::t_rsp o_rsp,
    output logic          empty
);
    import mlf_pkg::*;

    localparam int EFF_COLS = (PANEL_COLUMNS / 8) * 8;

    t_cmd front_cmd;
    logic front_keep;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    t_cmd cmd_head;
    logic out_push;
    t_rsp out_word;
    logic out_full;
    logic clearing;

    assign full = cmd_full || clearing;

    mlf_front #(
        .EFF_COLS (EFF_COLS),
        .ROWS     (PANEL_ROWS)
    ) u_front (
        .i_req  (i_req),
        .o_keep (front_keep),
        .o_cmd  (front_cmd)
    );

    mlf_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full && front_keep),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    mlf_back #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_ROWS    (PANEL_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_out_push  (out_push),
        .o_out       (out_word),
        .i_out_full  (out_full),
        .o_clearing  (clearing)
    );

    mlf_fifo #(
        .T     (t_rsp),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_word),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_rsp),
        .o_empty (empty)
    );

`ifndef SYNTH
    // No request may enter while the frame store is still being swept.
    a_full_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> full)
        else $error("request port open during frame store sweep");

    // Nothing can be produced before the sweep has finished.
    a_no_result_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (empty && cmd_empty))
        else $error("result or command present during frame store sweep");

    // The back end takes a command only when one is queued.
    a_cmd_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from empty queue");
`endif

endmodule

### verif/memory_lcd_line_checker.sv
// Checker that predicts and compares the serial bytes of the memory LCD line formatter.
`timescale 1ns / 100ps

module memory_lcd_line_checker #(
    parameter int PANEL_COLUMNS = mlf_pkg::DEF_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = mlf_pkg::DEF_PANEL_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  mlf_pkg::t_req i_req,
    input  logic          full,
    input  logic          pop,
    input  mlf_pkg::t_rsp o_rsp,
    input  logic          empty,
    output int            o_mismatches,
    output int            o_pending,
    output int            o_bytes_checked
);
    import mlf_pkg::*;

    localparam int LINE_BYTES  = PANEL_COLUMNS / 8;
    localparam int PIXEL_COLS  = LINE_BYTES * 8;
    localparam int STORE_BYTES = PANEL_ROWS * LINE_BYTES;
    localparam int PRINT_CAP   = 100;

    logic [7:0] frame_model [STORE_BYTES];
    t_rsp       expected_bytes [$];
    t_rsp       oldest;
    int         mismatch_total = 0;
    int         bytes_checked  = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_total < PRINT_CAP) begin
            $display("%0t ns mismatch: %s", $realtime, msg);
        end
        mismatch_total++;
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic is_last);
        t_rsp w;
        w.out_byte = value;
        w.last     = is_last;
        expected_bytes.push_back(w);
    endtask

    task automatic paint_pixel(input int col, input int row, input logic color);
        int idx;
        if (col >= PIXEL_COLS || row >= PANEL_ROWS) begin
            return;
        end
        idx = row * LINE_BYTES + col / 8;
        // The leftmost pixel of a byte sits in its most significant bit.
        frame_model[idx][7 - (col % 8)] = color;
    endtask

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = v[7 - i];
        end
        return m;
    endfunction

    task automatic format_request(input t_req r);
        int col_end;
        int row_end;
        int line_no;
        logic [7:0] cmd;
        case (r.req_type)
            REQ_PIXEL: begin
                paint_pixel(r.x, r.y, r.color);
            end
            REQ_RECT: begin
                col_end = int'(r.x) + int'(r.rect_width);
                row_end = int'(r.y) + int'(r.rect_height);
                if (col_end > PIXEL_COLS) col_end = PIXEL_COLS;
                if (row_end > PANEL_ROWS) row_end = PANEL_ROWS;
                for (int j = r.y; j < row_end; j++) begin
                    for (int i = r.x; i < col_end; i++) begin
                        paint_pixel(i, j, r.color);
                    end
                end
            end
            REQ_REFRESH: begin
                if (r.refresh_row < PANEL_ROWS) begin
                    line_no = int'(r.refresh_row) + 1;
                    cmd     = LINE_CMD_BYTE;
                    cmd[1]  = line_no[1];
                    queue_byte(cmd, 1'b0);
                    queue_byte(line_no[7:0], 1'b0);
                    for (int k = 0; k < LINE_BYTES; k++) begin
                        queue_byte(mirror_byte(frame_model[r.refresh_row * LINE_BYTES + k]),
                                   1'b0);
                    end
                    queue_byte(TRAILER_BYTE, 1'b0);
                    queue_byte(TRAILER_BYTE, 1'b1);
                end
            end
            REQ_CLEAR: begin
                queue_byte(CLEAR_CMD_BYTE, 1'b0);
                queue_byte(TRAILER_BYTE, 1'b1);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_BYTES; i++) begin
                frame_model[i] = 8'h00;
            end
            expected_bytes.delete();
        end else begin
            if (push && !full) begin
                format_request(i_req);
            end
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("word %02h last %0b with nothing expected",
                                              o_rsp.out_byte, o_rsp.last));
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (o_rsp.out_byte !== oldest.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  o_rsp.out_byte, oldest.out_byte));
                    end
                    if (o_rsp.last !== oldest.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                                  o_rsp.last, oldest.last, oldest.out_byte));
                    end
                    bytes_checked++;
                end
            end
        end
        o_mismatches    <= mismatch_total;
        o_pending       <= expected_bytes.size();
        o_bytes_checked <= bytes_checked;
    end

endmodule

### verif/tb_memory_lcd_frame_line_formatter_unit.sv
// Testbench top: stimulus and verdict for the memory LCD frame line formatter.
`timescale 1ns / 100ps

module tb_memory_lcd_frame_line_formatter_unit;
    import mlf_pkg::*;

    localparam int RANDOM_ITEMS = 307;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_ITEM = 60;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    t_req i_req   = '0;
    logic pop     = 1'b0;
    logic full;
    logic empty;
    t_rsp o_rsp;

    int mismatches;
    int pending_bytes;
    int bytes_checked;

    int  kind_count [4];
    int  burst_left      = 0;
    int  last_row        = 0;
    int  stalled_in_hold = 0;
    int  held_cycles     = 0;
    bit  hold_wanted     = 1'b0;
    bit  hold_active     = 1'b0;

    memory_lcd_frame_line_formatter_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_req   (i_req),
        .full    (full),
        .pop     (pop),
        .o_rsp   (o_rsp),
        .empty   (empty)
    );

    memory_lcd_line_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .i_req           (i_req),
        .full            (full),
        .pop             (pop),
        .o_rsp           (o_rsp),
        .empty           (empty),
        .o_mismatches    (mismatches),
        .o_pending       (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_600_000;
        $display("TB_ERROR");
        $finish;
    end

    // Fields a request does not use carry random values.
    function automatic t_req req_of(input logic [1:0] kind, input int x, input int y,
                                    input int w, input int h, input logic color,
                                    input int row);
        t_req r;
        r.req_type    = kind;
        r.x           = 7'($urandom_range(0, 127));
        r.y           = 7'($urandom_range(0, 127));
        r.rect_width  = 8'($urandom_range(0, 255));
        r.rect_height = 8'($urandom_range(0, 255));
        r.color       = 1'($urandom_range(0, 1));
        r.refresh_row = 7'($urandom_range(0, 127));
        if (kind == REQ_PIXEL || kind == REQ_RECT) begin
            r.x     = 7'(x);
            r.y     = 7'(y);
            r.color = color;
        end
        if (kind == REQ_RECT) begin
            r.rect_width  = 8'(w);
            r.rect_height = 8'(h);
        end
        if (kind == REQ_REFRESH) begin
            r.refresh_row = 7'(row);
        end
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r = req_of(REQ_PIXEL, $urandom_range(0, 127), $urandom_range(0, 127), 0, 0,
                       1'($urandom_range(0, 1)), 0);
        end else if (pick < 55) begin
            r = req_of(REQ_RECT, $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(1, 12), $urandom_range(1, 12),
                       1'($urandom_range(0, 1)), 0);
            case ($urandom_range(0, 19))
                0: begin
                    // Rectangle running past the right and bottom edges.
                    r.x           = 7'($urandom_range(100, 127));
                    r.y           = 7'($urandom_range(100, 127));
                    r.rect_width  = 8'($urandom_range(0, 255));
                    r.rect_height = 8'($urandom_range(0, 255));
                end
                1: begin
                    r.rect_width  = 8'($urandom_range(64, 128));
                    r.rect_height = 8'($urandom_range(64, 128));
                end
                2: begin
                    r.rect_width  = '0;
                end
                3: begin
                    r.rect_height = '0;
                end
                default: ;
            endcase
        end else if (pick < 90) begin
            // Half the refreshes read back a row that was just drawn on.
            r = req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0,
                       ($urandom_range(0, 1) == 1) ? last_row : $urandom_range(0, 127));
        end else begin
            r = req_of(REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0);
        end
        return r;
    endfunction

    task automatic send_word(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) begin
            if (hold_active) stalled_in_hold++;
            @(posedge i_clk);
        end
        burst_left--;
        kind_count[r.req_type]++;
        if (r.req_type == REQ_PIXEL || r.req_type == REQ_RECT) begin
            last_row = r.y;
        end
    endtask

    // Receiver: runs of random stall density, one long hold-off once HOLD_AT_ITEM random items are sent.
    initial begin : receiver
        int run_left;
        int stall_pct;
        run_left  = 0;
        stall_pct = 0;
        @(posedge i_clk);
        forever begin
            if (hold_wanted && held_cycles == 0) begin
                pop         <= 1'b0;
                hold_active = 1'b1;
                while (held_cycles < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held_cycles++;
                end
                hold_active = 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                run_left--;
                pop <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin : sender
        t_req directed [$];
        for (int i = 0; i < 4; i++) kind_count[i] = 0;
        directed.push_back(req_of(REQ_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        directed.push_back(req_of(REQ_PIXEL, 127, 127, 0, 0, 1'b1, 0));
        directed.push_back(req_of(REQ_PIXEL, 127, 0, 0, 0, 1'b1, 0));
        directed.push_back(req_of(REQ_PIXEL, 0, 127, 0, 0, 1'b1, 0));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 0));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 127));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 1));
        directed.push_back(req_of(REQ_RECT, 120, 1, 255, 255, 1'b1, 0));
        directed.push_back(req_of(REQ_RECT, 5, 5, 0, 40, 1'b1, 0));
        directed.push_back(req_of(REQ_RECT, 5, 5, 40, 0, 1'b1, 0));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 2));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 126));
        directed.push_back(req_of(REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0));
        directed.push_back(req_of(REQ_RECT, 0, 0, 128, 128, 1'b1, 0));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 64));
        directed.push_back(req_of(REQ_PIXEL, 127, 127, 0, 0, 1'b0, 0));
        directed.push_back(req_of(REQ_PIXEL, 3, 64, 0, 0, 1'b0, 0));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 127));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 64));
        directed.push_back(req_of(REQ_RECT, 0, 0, 128, 128, 1'b0, 0));
        directed.push_back(req_of(REQ_RECT, 7, 9, 10, 3, 1'b1, 0));
        directed.push_back(req_of(REQ_REFRESH, 0, 0, 0, 0, 1'b0, 9));
        directed.push_back(req_of(REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_word(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM) hold_wanted = 1'b1;
            send_word(random_request());
        end
        push <= 1'b0;

        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d pixel, %0d rectangle, %0d refresh and %0d clear requests;",
                 kind_count[REQ_PIXEL], kind_count[REQ_RECT], kind_count[REQ_REFRESH],
                 kind_count[REQ_CLEAR]);
        $display("%0d bytes compared; output held off for %0d cycles, input refused %0d.",
                 bytes_checked, held_cycles, stalled_in_hold);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
